// File: design/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types and constants for the run-length encoder with decimal counts.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int COUNT_DIGITS_DEF = 5;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ERR_BYTE   = 8'h00;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       line_done;
    logic       digit_error;
  } out_item_t;

endpackage

// File: design/rle_front.sv
// ----------------------------------------------------------------------------
// rle_front
// Accepts line bytes, tracks the open run and its BCD length, and queues a
// request for each item that writes output.
// ----------------------------------------------------------------------------
module rle_front #(
  parameter int COUNT_DIGITS = rle_pkg::COUNT_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  rle_pkg::in_item_t          in_data,
  output logic                       in_stall,
  input  logic                       q_full,
  output logic                       q_push,
  output logic [4*COUNT_DIGITS+19:0] q_push_data
);

  localparam int BCD_W = 4 * COUNT_DIGITS;

  typedef struct packed {
    logic             a_valid;
    logic [BCD_W-1:0] a_bcd;
    logic [7:0]       a_char;
    logic             b_valid;
    logic [7:0]       b_char;
    logic             err;
    logic             line_end;
  } entry_t;

  logic [7:0]       run_char_r, run_char_nxt;
  logic [BCD_W-1:0] run_bcd_r, run_bcd_nxt;
  logic             run_open_r, run_open_nxt;
  logic             failed_r, failed_nxt;

  logic [BCD_W-1:0] inc_bcd;
  logic [BCD_W-1:0] one_bcd;
  logic             inc_nines;
  logic [3:0]       dig;
  logic             carry;
  logic             accept;
  logic             is_digit;
  entry_t           ent;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_digit = (in_data.in_byte >= rle_pkg::ASCII_ZERO) &&
                    (in_data.in_byte <= rle_pkg::ASCII_NINE);
  assign one_bcd  = {{(BCD_W-1){1'b0}}, 1'b1};

  // decimal ripple increment of the run length
  always_comb begin
    carry   = 1'b1;
    inc_bcd = '0;
    dig     = '0;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      dig = run_bcd_r[4*i +: 4];
      if (carry && (dig >= 4'd9)) begin
        inc_bcd[4*i +: 4] = 4'd0;
      end else begin
        inc_bcd[4*i +: 4] = dig + {3'b000, carry};
        carry             = 1'b0;
      end
    end
  end

  assign inc_nines = (inc_bcd == {COUNT_DIGITS{4'h9}});

  always_comb begin
    ent          = '0;
    q_push       = 1'b0;
    run_char_nxt = run_char_r;
    run_bcd_nxt  = run_bcd_r;
    run_open_nxt = run_open_r;
    failed_nxt   = failed_r;
    ent.line_end = in_data.line_end;
    if (accept) begin
      if (failed_r || is_digit) begin
        ent.err      = 1'b1;
        q_push       = in_data.line_end;
        failed_nxt   = 1'b1;
        run_open_nxt = 1'b0;
        run_bcd_nxt  = '0;
      end else if (run_open_r && (in_data.in_byte == run_char_r)) begin
        // same byte: grow, flush at line end or at the top count
        ent.a_valid  = inc_nines || in_data.line_end;
        ent.a_bcd    = inc_bcd;
        ent.a_char   = run_char_r;
        q_push       = ent.a_valid;
        run_bcd_nxt  = ent.a_valid ? '0 : inc_bcd;
        run_open_nxt = !ent.a_valid;
      end else begin
        // new byte: close the old run, open a run of one (or emit it alone at line end)
        ent.a_valid  = run_open_r;
        ent.a_bcd    = run_bcd_r;
        ent.a_char   = run_char_r;
        ent.b_valid  = in_data.line_end;
        ent.b_char   = in_data.in_byte;
        q_push       = run_open_r || in_data.line_end;
        run_char_nxt = in_data.in_byte;
        run_bcd_nxt  = in_data.line_end ? '0 : one_bcd;
        run_open_nxt = !in_data.line_end;
      end
      if (in_data.line_end) begin
        run_char_nxt = '0;
        run_bcd_nxt  = '0;
        run_open_nxt = 1'b0;
        failed_nxt   = 1'b0;
      end
    end
  end

  assign q_push_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_char_r <= '0;
      run_bcd_r  <= '0;
      run_open_r <= 1'b0;
      failed_r   <= 1'b0;
    end else begin
      run_char_r <= run_char_nxt;
      run_bcd_r  <= run_bcd_nxt;
      run_open_r <= run_open_nxt;
      failed_r   <= failed_nxt;
    end
  end

endmodule

// File: design/rle_queue.sv
// ----------------------------------------------------------------------------
// rle_queue
// Small register FIFO of flush requests between the front and the back.
// ----------------------------------------------------------------------------
module rle_queue #(
  parameter int WIDTH = 40,
  parameter int DEPTH = rle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: design/rle_back.sv
// ----------------------------------------------------------------------------
// rle_back
// Walks the head request one byte per cycle when unstalled: count digits,
// run byte, trailing single byte, or the error result, into a registered output.
// ----------------------------------------------------------------------------
module rle_back #(
  parameter int COUNT_DIGITS = rle_pkg::COUNT_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  logic [4*COUNT_DIGITS+19:0] q_rd_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rle_pkg::out_item_t         out_data
);

  localparam int BCD_W = 4 * COUNT_DIGITS;
  localparam int IDX_W = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

  localparam logic [2:0] PH_FRESH = 3'd0;
  localparam logic [2:0] PH_DIG   = 3'd1;
  localparam logic [2:0] PH_A     = 3'd2;
  localparam logic [2:0] PH_B     = 3'd3;
  localparam logic [2:0] PH_ERR   = 3'd4;

  typedef struct packed {
    logic             a_valid;
    logic [BCD_W-1:0] a_bcd;
    logic [7:0]       a_char;
    logic             b_valid;
    logic [7:0]       b_char;
    logic             err;
    logic             line_end;
  } entry_t;

  entry_t             head;
  logic [2:0]         phase_r, phase_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               out_valid_r;
  rle_pkg::out_item_t out_data_r;
  rle_pkg::out_item_t emit;

  logic [IDX_W-1:0]   top;
  logic               multi;
  logic [2:0]         cur_ph;
  logic [IDX_W-1:0]   cur_idx;
  logic [3:0]         cur_dig;
  logic               adv;
  logic               done;

  assign head = q_rd_data;
  assign adv  = q_not_empty && (!out_valid_r || !out_stall);

  // highest nonzero count digit
  always_comb begin
    top = '0;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (head.a_bcd[4*i +: 4] != 4'd0) begin
        top = IDX_W'(i);
      end
    end
  end

  assign multi = (top != '0) || (head.a_bcd[3:0] > 4'd1);

  always_comb begin
    cur_idx = idx_r;
    cur_ph  = phase_r;
    if (phase_r == PH_FRESH) begin
      cur_idx = top;
      if (head.err) begin
        cur_ph = PH_ERR;
      end else if (head.a_valid) begin
        cur_ph = multi ? PH_DIG : PH_A;
      end else begin
        cur_ph = PH_B;
      end
    end
  end

  assign cur_dig = head.a_bcd[4*cur_idx +: 4];

  always_comb begin
    emit      = '0;
    done      = 1'b0;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    case (cur_ph)
      PH_DIG: begin
        emit.out_byte = rle_pkg::ASCII_ZERO + {4'h0, cur_dig};
        phase_nxt     = (cur_idx == '0) ? PH_A : PH_DIG;
        idx_nxt       = cur_idx - 1'b1;
      end
      PH_A: begin
        emit.out_byte = head.a_char;
        done          = !head.b_valid;
        phase_nxt     = PH_B;
      end
      PH_B: begin
        emit.out_byte = head.b_char;
        done          = 1'b1;
      end
      PH_ERR: begin
        emit.out_byte    = rle_pkg::ERR_BYTE;
        emit.digit_error = 1'b1;
        done             = 1'b1;
      end
      default: begin
        emit.out_byte = rle_pkg::ERR_BYTE;
        done          = 1'b1;
      end
    endcase
    emit.last_of_item = done;
    emit.line_done    = done && head.line_end;
    if (done) begin
      phase_nxt = PH_FRESH;
    end
  end

  assign q_pop     = adv && done;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FRESH;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        phase_r     <= phase_nxt;
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: design/rle_ascii_count_encoder.sv
// ----------------------------------------------------------------------------
// rle_ascii_count_encoder
// Run-length encoder with ASCII decimal counts; one line byte per request.
// ----------------------------------------------------------------------------
// path: a taken request is queued, then the back registers its bytes on out_valid
// throughput: one input byte per cycle while the request queue has room
// output: one encoded byte per cycle while out_stall is low; a flush of k count
//   digits gives k+1 or k+2 output bytes, which the request queue absorbs
// reset: synchronous, clears the open run, the queue and the output valid flag
module rle_ascii_count_encoder #(
  parameter int COUNT_DIGITS = rle_pkg::COUNT_DIGITS_DEF,
  parameter int QUEUE_DEPTH  = rle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  rle_pkg::in_item_t  in_data,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output rle_pkg::out_item_t out_data
);

  localparam int ENT_W = 4 * COUNT_DIGITS + 20;

  logic             q_push, q_full, q_pop, q_not_empty;
  logic [ENT_W-1:0] q_push_data, q_rd_data;

  rle_front #(
    .COUNT_DIGITS(COUNT_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  rle_queue #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .rd_data   (q_rd_data),
    .not_empty (q_not_empty)
  );

  rle_back #(
    .COUNT_DIGITS(COUNT_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rd_data   (q_rd_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// File: bench/rle_ascii_count_encoder_tb.sv
// ----------------------------------------------------------------------------
// rle_ascii_count_encoder_tb
// Drives byte lines into the run-length encoder and checks every encoded byte
// against an in-bench predictor of runs, BCD counts and digit rejection, with
// random idling on both channels and a long output hold.
// ----------------------------------------------------------------------------
module rle_ascii_count_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGITS      = rle_pkg::COUNT_DIGITS_DEF;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_PRINTED = 40;

  typedef logic [4*DIGITS-1:0] bcd_count_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  rle_pkg::in_item_t  in_data;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall;
  rle_pkg::out_item_t out_data;

  rle_ascii_count_encoder #(
    .COUNT_DIGITS(DIGITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // encoder state as predicted
  logic [7:0] cur_byte  = '0;
  bcd_count_t cur_count = '0;
  bit         run_held  = 1'b0;
  bit         line_bad  = 1'b0;

  rle_pkg::out_item_t step_bytes[$];
  rle_pkg::out_item_t pending_bytes[$];

  bit          stall_en = 1'b1;
  bit          gap_en   = 1'b1;
  int          hold_len = 0;
  int unsigned cycle_count    = 0;
  int unsigned n_sent         = 0;
  int unsigned n_requests     = 0;
  int unsigned n_lines        = 0;
  int unsigned n_error_lines  = 0;
  int unsigned n_results      = 0;
  int unsigned n_mismatches   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_bytes.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic bcd_count_t bcd_next(bcd_count_t v);
    bcd_count_t r;
    logic       carry;
    logic [3:0] d;
    int         i;
    r     = '0;
    carry = 1'b1;
    for (i = 0; i < DIGITS; i++) begin
      d = v[4*i +: 4];
      if (carry) begin
        if (d == 4'd9) begin
          d = 4'd0;
        end else begin
          d     = d + 4'd1;
          carry = 1'b0;
        end
      end
      r[4*i +: 4] = d;
    end
    return r;
  endfunction

  function automatic rle_pkg::out_item_t plain_byte(logic [7:0] b);
    rle_pkg::out_item_t item;
    item              = '0;
    item.out_byte     = b;
    return item;
  endfunction

  task automatic clear_line_state();
    cur_byte  = '0;
    cur_count = '0;
    run_held  = 1'b0;
    line_bad  = 1'b0;
  endtask

  // count digits (no leading zeros, skipped for a single byte) then the byte
  task automatic emit_run();
    int i;
    int top;
    if (!run_held) return;
    top = -1;
    for (i = DIGITS - 1; i >= 0; i--) begin
      if (top < 0 && cur_count[4*i +: 4] != 4'd0) top = i;
    end
    if (top > 0 || (top == 0 && cur_count[3:0] > 4'd1)) begin
      for (i = top; i >= 0; i--) begin
        step_bytes.push_back(plain_byte(rle_pkg::ASCII_ZERO + 8'(cur_count[4*i +: 4])));
      end
    end
    step_bytes.push_back(plain_byte(cur_byte));
    run_held  = 1'b0;
    cur_count = '0;
  endtask

  task automatic encode_request(rle_pkg::in_item_t req);
    logic               is_digit;
    rle_pkg::out_item_t item;
    is_digit = (req.in_byte >= rle_pkg::ASCII_ZERO) && (req.in_byte <= rle_pkg::ASCII_NINE);
    step_bytes.delete();
    if (line_bad || is_digit) begin
      // rest of a rejected line is dropped, one error marker at its end
      line_bad  = 1'b1;
      run_held  = 1'b0;
      cur_count = '0;
      if (req.line_end) begin
        item              = plain_byte(rle_pkg::ERR_BYTE);
        item.last_of_item = 1'b1;
        item.line_done    = 1'b1;
        item.digit_error  = 1'b1;
        pending_bytes.push_back(item);
        n_error_lines++;
        clear_line_state();
      end
      return;
    end
    if (run_held && req.in_byte == cur_byte) begin
      cur_count = bcd_next(cur_count);
    end else begin
      emit_run();
      cur_byte  = req.in_byte;
      cur_count = bcd_count_t'(1);
      run_held  = 1'b1;
    end
    // a full counter is flushed at once
    if (cur_count == {DIGITS{4'h9}} || req.line_end) emit_run();
    if (step_bytes.size() > 0) begin
      item              = step_bytes.pop_back();
      item.last_of_item = 1'b1;
      item.line_done    = req.line_end;
      step_bytes.push_back(item);
    end
    foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
    if (req.line_end) clear_line_state();
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    n_mismatches++;
    if (n_mismatches <= MAX_PRINTED) begin
      $display("%0t mismatch on %s: got %02h, expected %02h (result %0d)",
               $time, what, got, want, n_results);
    end
  endtask

  task automatic check_result(rle_pkg::out_item_t got);
    rle_pkg::out_item_t want;
    n_results++;
    if (pending_bytes.size() == 0) begin
      report_mismatch("unexpected result, out_byte", got.out_byte, 8'h00);
      return;
    end
    want = pending_bytes.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch("out_byte", got.out_byte, want.out_byte);
    if (got.last_of_item !== want.last_of_item)
      report_mismatch("last_of_item", 8'(got.last_of_item), 8'(want.last_of_item));
    if (got.line_done !== want.line_done)
      report_mismatch("line_done", 8'(got.line_done), 8'(want.line_done));
    if (got.digit_error !== want.digit_error)
      report_mismatch("digit_error", 8'(got.digit_error), 8'(want.digit_error));
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      encode_request(in_data);
      n_requests++;
      if (in_data.line_end) n_lines++;
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) check_result(out_data);
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_stall <= 1'b0;
      end else if (stall_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // valid stays high after acceptance unless a random gap is drawn, so back-to-back requests need no toggle
  task automatic push_request(logic [7:0] b, logic last);
    rle_pkg::in_item_t req;
    req.in_byte  = b;
    req.line_end = last;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    n_sent++;
    if (gap_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_request(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  function automatic logic [7:0] plain_random_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b >= rle_pkg::ASCII_ZERO && b <= rle_pkg::ASCII_NINE);
    return b;
  endfunction

  // a line built from runs, mostly over a narrow alphabet so runs merge
  task automatic send_line(int max_len, bit with_digits);
    logic [7:0] line_q[$];
    logic [7:0] ch;
    int         len;
    int         rl;
    int         pos;
    len = $urandom_range(1, max_len);
    while (line_q.size() < len) begin
      ch = ($urandom_range(0, 4) < 3) ? 8'(8'h61 + $urandom_range(0, 2))
                                       : plain_random_byte();
      rl = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 3);
      repeat (rl) if (line_q.size() < len) line_q.push_back(ch);
    end
    if (with_digits && $urandom_range(0, 7) == 0) begin
      pos         = $urandom_range(0, len - 1);
      line_q[pos] = rle_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
    end
    foreach (line_q[i]) push_request(line_q[i], i == line_q.size() - 1);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_edge_bytes();
    push_request(8'h00, 1'b1);
    repeat (3) push_request(8'hFF, 1'b0);
    push_request(8'h00, 1'b1);
    // neighbors of the digit range and the top bit
    push_request(8'h2F, 1'b0);
    push_request(8'h3A, 1'b0);
    push_request(8'h80, 1'b0);
    push_request(8'h7F, 1'b1);
    wait_drained();
  endtask

  task automatic test_digit_lines();
    send_text("aa5b");
    send_text("0");
    send_text("q9q");
    wait_drained();
  endtask

  task automatic test_count_digits();
    send_text("zzzzzzzzzz");
    send_text("mmn");
    wait_drained();
  endtask

  task automatic test_backpressure();
    int unsigned start;
    start    = n_sent;
    gap_en   = 1'b0;
    hold_len = 300;
    while (n_sent - start < 40) send_line(24, 1'b0);
    gap_en = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_lines();
    int unsigned start;
    start    = n_sent;
    stall_en = 1'b1;
    gap_en   = 1'b1;
    while (n_sent - start < 100) begin
      send_line(24, 1'b1);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_steady_stream();
    int unsigned start;
    start    = n_sent;
    stall_en = 1'b0;
    gap_en   = 1'b0;
    while (n_sent - start < 40) send_line(24, 1'b1);
    wait_drained();
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_bytes();
    test_digit_lines();
    test_count_digits();
    test_backpressure();
    test_random_lines();
    test_steady_stream();

    repeat (10) @(posedge clk);
    if (pending_bytes.size() != 0)
      report_mismatch("missing results, count", 8'(pending_bytes.size()), 8'h00);
    $display("%0d requests in %0d lines (%0d rejected for digits), %0d results checked",
             n_requests, n_lines, n_error_lines, n_results);
    $display("runs: edge bytes, digit lines, multi-digit counts, a long hold, no idle");
    if (n_mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
